// ===== hdl/alsid_pkg.sv =====
package alsid_pkg;

  // Field widths of the request and response items.
  localparam int unsigned KindW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;

  localparam int unsigned DepthDefault = 16;

  // Operation codes.
  localparam logic [KindW-1:0] KindSearch = 2'd0;
  localparam logic [KindW-1:0] KindInsert = 2'd1;
  localparam logic [KindW-1:0] KindDelete = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd1;
  localparam logic [StatusW-1:0] StatusFull     = 2'd2;
  localparam logic [StatusW-1:0] StatusBadPos   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and the compare vector
    logic commit;   // apply the operation and load the response register
  } alsid_cmd_t;

endpackage

// ===== hdl/alsid_intf.sv =====
interface alsid_req_if;
  logic                               valid;
  logic                               ready;
  logic [alsid_pkg::KindW-1:0]        kind;
  logic signed [alsid_pkg::ValueW-1:0] value;
  logic [alsid_pkg::PosW-1:0]         position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink (input valid, input kind, input value, input position, output ready);
endinterface

interface alsid_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [alsid_pkg::StatusW-1:0] status;
  logic [alsid_pkg::IndexW-1:0]  index;
  logic [alsid_pkg::CountW-1:0]  count;

  modport source (output valid, output status, output index, output count, input ready);
  modport sink (input valid, input status, input index, input count, output ready);
endinterface

// ===== hdl/array_list_search_insert_delete.sv =====
// Compact list of signed 32-bit values with search, insert and delete.
// Request channel req_i carries kind (search, insert, delete), value and a
// 1-based insert position; response channel rsp_o returns status, the 0-based
// index found, removed or written, and the fill count after the operation.
// Both channels use valid/ready; an item moves when both are high.
// A new request is taken only after the last one has committed. The capture
// step compares all cells against the value in parallel and registers the
// match vector; the execute step picks the lowest match, shifts the cells,
// updates the count and loads the response register.
// Reset clears the fill count and both handshakes; cell contents are left
// as they are and are only read below the fill count.
// Receiver stall: the response holds in its output register. The block still
// takes one more request and finishes its compare, then waits in the execute
// step until the held response is taken.
// Kind 3 is ignored: status ok, index zero, count unchanged.
module array_list_search_insert_delete #(
  parameter int unsigned Depth = alsid_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alsid_req_if.sink   req_i,
  alsid_rsp_if.source rsp_o
);

  alsid_pkg::alsid_cmd_t cmd;

  // Handshake sequencing and response-register occupancy.
  alsid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Cells, compare vector, shift network and response register.
  alsid_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .kind_i     (req_i.kind),
    .value_i    (req_i.value),
    .position_i (req_i.position),
    .status_o   (rsp_o.status),
    .index_o    (rsp_o.index),
    .count_o    (rsp_o.count)
  );

endmodule

// ===== hdl/alsid_ctrl.sv =====
module alsid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output alsid_pkg::alsid_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic rsp_valid_q, rsp_valid_d;
  logic take, commit;

  assign take   = (state_q == StIdle) && req_valid_i;
  // Commit only when the response register is free or drains this cycle.
  assign commit = (state_q == StExec) && (!rsp_valid_q || rsp_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take) state_d = StExec;
      end
      StExec: begin
        if (commit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o   = (state_q == StIdle);
  assign rsp_valid_o   = rsp_valid_q;
  assign cmd_o.capture = take;
  assign cmd_o.commit  = commit;

endmodule

// ===== hdl/alsid_dp.sv =====
module alsid_dp #(
  parameter int unsigned Depth = alsid_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  alsid_pkg::alsid_cmd_t               cmd_i,
  input  logic [alsid_pkg::KindW-1:0]         kind_i,
  input  logic signed [alsid_pkg::ValueW-1:0] value_i,
  input  logic [alsid_pkg::PosW-1:0]          position_i,
  output logic [alsid_pkg::StatusW-1:0]       status_o,
  output logic [alsid_pkg::IndexW-1:0]        index_o,
  output logic [alsid_pkg::CountW-1:0]        count_o
);

  localparam int unsigned IW   = $clog2(Depth);
  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned CmpW = ((CW > alsid_pkg::PosW) ? CW : alsid_pkg::PosW) + 1;

  // List cells and fill count.
  logic signed [alsid_pkg::ValueW-1:0] cell_q [Depth];
  logic [CW-1:0]                       fill_q, fill_d;

  // Latched request and per-cell match vector.
  logic [alsid_pkg::KindW-1:0]         kind_q;
  logic signed [alsid_pkg::ValueW-1:0] value_q;
  logic [alsid_pkg::PosW-1:0]          pos_q;
  logic [Depth-1:0]                    hit_q, hit_d;

  // Response register.
  logic [alsid_pkg::StatusW-1:0] status_q, status_d;
  logic [alsid_pkg::IndexW-1:0]  index_q, index_d;
  logic [alsid_pkg::CountW-1:0]  count_q, count_d;

  logic          found;
  logic [IW-1:0] hit_idx;
  logic [CmpW-1:0] pos_ext, fill_ext;
  logic          list_full, bad_pos;
  logic [IW-1:0] ins_idx;
  logic          do_insert, do_delete;
  logic [IW-1:0] res_idx;
  logic [IW+alsid_pkg::IndexW-1:0] res_idx_ext;
  logic [CW+alsid_pkg::CountW-1:0] fill_ext_out;

  // Compare every valid cell against the incoming value.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      hit_d[i] = (cell_q[i] == value_i) && (CW'(i) < fill_q);
    end
  end

  // Lowest matching cell wins.
  always_comb begin
    found   = |hit_q;
    hit_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit_q[i]) hit_idx = IW'(i);
    end
  end

  assign pos_ext   = CmpW'(pos_q);
  assign fill_ext  = CmpW'(fill_q);
  assign list_full = (fill_q == CW'(Depth));
  assign bad_pos   = (pos_q == '0) || (pos_ext > fill_ext + CmpW'(1));
  assign ins_idx   = IW'(pos_ext - CmpW'(1));

  assign do_insert = (kind_q == alsid_pkg::KindInsert) && !list_full && !bad_pos;
  assign do_delete = (kind_q == alsid_pkg::KindDelete) && found;

  always_comb begin
    status_d = alsid_pkg::StatusOk;
    res_idx  = '0;
    fill_d   = fill_q;
    case (kind_q)
      alsid_pkg::KindSearch: begin
        if (found) res_idx = hit_idx;
        else       status_d = alsid_pkg::StatusNotFound;
      end
      alsid_pkg::KindInsert: begin
        if (list_full) begin
          status_d = alsid_pkg::StatusFull;
        end else if (bad_pos) begin
          status_d = alsid_pkg::StatusBadPos;
        end else begin
          res_idx = ins_idx;
          fill_d  = fill_q + CW'(1);
        end
      end
      alsid_pkg::KindDelete: begin
        if (found) begin
          res_idx = hit_idx;
          fill_d  = fill_q - CW'(1);
        end else begin
          status_d = alsid_pkg::StatusNotFound;
        end
      end
      default: ;
    endcase
  end

  // Mask index and count to the response field widths.
  assign res_idx_ext  = {{alsid_pkg::IndexW{1'b0}}, res_idx};
  assign fill_ext_out = {{alsid_pkg::CountW{1'b0}}, fill_d};
  assign index_d      = res_idx_ext[alsid_pkg::IndexW-1:0];
  assign count_d      = fill_ext_out[alsid_pkg::CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.commit) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      pos_q   <= position_i;
      hit_q   <= hit_d;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      index_q  <= index_d;
      count_q  <= count_d;
    end
  end

  // Insert moves cells above the slot up; delete moves those from the hit down.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && do_insert) begin
        if (IW'(g) == ins_idx) begin
          cell_q[g] <= value_q;
        end else if (g > 0 && IW'(g) > ins_idx) begin
          cell_q[g] <= cell_q[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd_i.commit && do_delete) begin
        if (g < Depth - 1 && IW'(g) >= hit_idx) begin
          cell_q[g] <= cell_q[(g < Depth - 1) ? g + 1 : g];
        end
      end
    end
  end

  assign status_o = status_q;
  assign index_o  = index_q;
  assign count_o  = count_q;

endmodule

// ===== test/tb_array_list_search_insert_delete.sv =====
`timescale 1ns / 100ps

module tb_array_list_search_insert_delete;
  import alsid_pkg::*;

  localparam int unsigned Depth         = DepthDefault;
  localparam int unsigned RandomItems   = 1000;  // kind 3 items not counted
  localparam int unsigned PhaseItems    = 100;   // items per operation mix
  localparam int unsigned CalmItems     = 150;   // closing stretch with no idling
  localparam int unsigned HoldOffAfter  = 400;   // responses before the long stall
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 8;     // quiet time to watch for stray responses
  localparam int unsigned StallLimit    = 2000;  // cycles with no handshake at all
  localparam int unsigned MaxPrinted    = 100;

  // The package names three kinds; the fourth code is accepted and ignored.
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  localparam logic signed [ValueW-1:0] ValueMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValueMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  index;
    logic [CountW-1:0]  count;
  } list_rsp_t;

  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
    bit                       typed;  // response written out in the table
    list_rsp_t                rsp;
  } list_op_t;

  // Operation mixes for the random part: grow fills the list and runs into
  // the full case, shrink drains it down to empty, balanced wanders between.
  typedef enum int {
    MixGrow,
    MixBalanced,
    MixShrink
  } op_mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  alsid_req_if req_if ();
  alsid_rsp_if rsp_if ();

  array_list_search_insert_delete #(
    .Depth(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Shadow of the list: cells below list_fill are live, the rest are don't-care.
  logic signed [ValueW-1:0] list_cells [Depth];
  int                       list_fill;

  list_rsp_t   pending_rsp [$];  // expected responses, oldest first
  int unsigned error_count;

  // Both sides skip their random idling while these are set.
  bit calm;      // closing stretch of the run
  bit hold_off;  // receiver is in its long stall; keep the request side busy

  // Apply one operation to the shadow list and return the response it gives.
  function automatic list_rsp_t apply_list_op(logic [KindW-1:0] kind,
                                              logic signed [ValueW-1:0] value,
                                              logic [PosW-1:0] position);
    list_rsp_t r;
    int        hit;
    int        slot;
    r    = '{status: StatusOk, index: '0, count: '0};
    hit  = -1;
    slot = int'(position) - 1;
    // Lowest matching live cell wins, as the priority encoder does.
    for (int i = 0; i < list_fill; i++) begin
      if (hit < 0 && list_cells[i] == value) hit = i;
    end
    case (kind)
      KindSearch: begin
        if (hit < 0) r.status = StatusNotFound;
        else r.index = IndexW'(hit);
      end
      KindInsert: begin
        // Full is checked before the position.
        if (list_fill >= Depth) begin
          r.status = StatusFull;
        end else if (position == '0 || int'(position) > list_fill + 1) begin
          r.status = StatusBadPos;
        end else begin
          for (int i = list_fill; i > slot; i--) list_cells[i] = list_cells[i-1];
          list_cells[slot] = value;
          list_fill++;
          r.index = IndexW'(slot);
        end
      end
      KindDelete: begin
        if (hit < 0) begin
          r.status = StatusNotFound;
        end else begin
          for (int i = hit; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
          list_fill--;
          r.index = IndexW'(hit);
        end
      end
      default: ;  // unused kind: no change
    endcase
    r.count = CountW'(list_fill);
    return r;
  endfunction

  function automatic list_op_t mk_op(logic [KindW-1:0] kind,
                                     logic signed [ValueW-1:0] value,
                                     logic [PosW-1:0] position,
                                     int typed = 0,
                                     logic [StatusW-1:0] status = StatusOk,
                                     int unsigned index = 0,
                                     int unsigned count = 0);
    list_op_t op;
    op.kind     = kind;
    op.value    = value;
    op.position = position;
    op.typed    = (typed != 0);
    op.rsp      = '{status, IndexW'(index), CountW'(count)};
    return op;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MaxPrinted) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Offer one request, hold it until accepted, then log its response.
  // Called at a rising edge; returns at the edge that accepted the item.
  task automatic issue_request(input list_op_t op);
    list_rsp_t predicted;
    if (!calm && !hold_off && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= op.kind;
    req_if.value    <= op.value;
    req_if.position <= op.position;
    do @(posedge clk_i); while (!req_if.ready);
    // Advance the shadow list even when the table gives the response.
    predicted = apply_list_op(op.kind, op.value, op.position);
    pending_rsp.push_back(op.typed ? op.rsp : predicted);
  endtask

  // Response side: check every accepted item, stall at random, and once
  // hold ready low long enough for the block to back up into its input.
  initial begin : collect_responses
    list_rsp_t   want;
    int unsigned seen;
    int unsigned stall_left;
    bit          stalled_long;
    seen         = 0;
    stall_left   = 0;
    stalled_long = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch($sformatf("response %0d with nothing expected: st=%0d idx=%0d cnt=%0d",
                                    seen, rsp_if.status, rsp_if.index, rsp_if.count));
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("response %0d status %0d, want %0d",
                                      seen, rsp_if.status, want.status));
          if (rsp_if.index !== want.index)
            report_mismatch($sformatf("response %0d index %0d, want %0d",
                                      seen, rsp_if.index, want.index));
          if (rsp_if.count !== want.count)
            report_mismatch($sformatf("response %0d count %0d, want %0d",
                                      seen, rsp_if.count, want.count));
        end
        seen++;
      end
      // Pick ready for the next cycle.
      if (!stalled_long && seen >= HoldOffAfter) begin
        stalled_long = 1'b1;
        hold_off     = 1'b1;
        stall_left   = HoldOffCycles;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        hold_off = 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run
    list_op_t                 directed_ops [$];
    list_op_t                 op;
    logic signed [ValueW-1:0] value_pool [8];
    op_mix_e                  mix;
    int unsigned              issued;
    int unsigned              roll;

    error_count = 0;
    calm        = 1'b0;
    hold_off    = 1'b0;
    list_fill   = 0;
    for (int i = 0; i < Depth; i++) list_cells[i] = '0;

    req_if.valid    <= 1'b0;
    req_if.kind     <= KindSearch;
    req_if.value    <= '0;
    req_if.position <= '0;

    // Directed table. Responses are typed in where they are plain to see;
    // the fill rows and the last delete are left to the shadow list.
    // Empty list: search and delete miss, no insert position but 1 is valid.
    directed_ops.push_back(mk_op(KindSearch, 32'sd5, 5'd1, 1, StatusNotFound, 0, 0));
    directed_ops.push_back(mk_op(KindDelete, -32'sd1, 5'd0, 1, StatusNotFound, 0, 0));
    directed_ops.push_back(mk_op(KindInsert, 32'sd7, 5'd0, 1, StatusBadPos, 0, 0));
    directed_ops.push_back(mk_op(KindInsert, 32'sd7, 5'd2, 1, StatusBadPos, 0, 0));
    // Value extremes, then the ignored kind with every position bit set.
    directed_ops.push_back(mk_op(KindInsert, ValueMin, 5'd1, 1, StatusOk, 0, 1));
    directed_ops.push_back(mk_op(KindInsert, ValueMax, 5'd2, 1, StatusOk, 1, 2));
    directed_ops.push_back(mk_op(KindUnused, 32'sd0, 5'd31, 1, StatusOk, 0, 2));
    directed_ops.push_back(mk_op(KindSearch, ValueMax, 5'd0, 1, StatusOk, 1, 2));
    directed_ops.push_back(mk_op(KindInsert, 32'sd3, 5'd31, 1, StatusBadPos, 0, 2));
    // Duplicate at the front: search and delete hit the lowest copy.
    directed_ops.push_back(mk_op(KindInsert, ValueMax, 5'd1, 1, StatusOk, 0, 3));
    directed_ops.push_back(mk_op(KindSearch, ValueMax, 5'd0, 1, StatusOk, 0, 3));
    directed_ops.push_back(mk_op(KindDelete, ValueMax, 5'd0, 1, StatusOk, 0, 2));
    // Append at fill + 1.
    directed_ops.push_back(mk_op(KindInsert, 32'sd0, 5'd3, 1, StatusOk, 2, 3));
    // Fill to Depth at random valid positions.
    for (int k = 0; k < Depth - 3; k++)
      directed_ops.push_back(mk_op(KindInsert, $urandom, PosW'($urandom_range(1, 4 + k))));
    // Full list: full wins over the bad position.
    directed_ops.push_back(mk_op(KindInsert, 32'sd9, 5'd0, 1, StatusFull, 0, Depth));
    directed_ops.push_back(mk_op(KindDelete, ValueMin, 5'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i]) issue_request(directed_ops[i]);

    // Random part: a small pool of values so that searches and deletes hit,
    // with fully random values mixed in for bit coverage.
    issued = 0;
    mix    = MixGrow;
    while (issued < RandomItems) begin
      if (issued % PhaseItems == 0) begin
        foreach (value_pool[i]) value_pool[i] = $urandom;
        value_pool[$urandom_range(0, 7)] = ValueMin;
        value_pool[$urandom_range(0, 7)] = ValueMax;
        case ((issued / PhaseItems) % 4)
          0:       mix = MixGrow;
          2:       mix = MixShrink;
          default: mix = MixBalanced;
        endcase
      end
      calm = (issued >= RandomItems - CalmItems);

      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op.kind = KindUnused;
      end else begin
        case (mix)
          MixGrow:   op.kind = roll < 65 ? KindInsert : (roll < 85 ? KindSearch : KindDelete);
          MixShrink: op.kind = roll < 65 ? KindDelete : (roll < 85 ? KindSearch : KindInsert);
          default:   op.kind = roll < 36 ? KindInsert : (roll < 68 ? KindSearch : KindDelete);
        endcase
      end
      op.value = ($urandom_range(0, 6) == 0) ? $urandom : value_pool[$urandom_range(0, 7)];
      // Mostly valid insert positions; the rest cover zero and past the end.
      if (op.kind == KindInsert && $urandom_range(0, 4) != 0)
        op.position = PosW'($urandom_range(1, list_fill + 1));
      else
        op.position = PosW'($urandom_range(0, 31));
      op.typed = 1'b0;
      op.rsp   = '0;

      issue_request(op);
      if (op.kind != KindUnused) issued++;
    end
    req_if.valid <= 1'b0;

    // Drain the outstanding responses, then watch for strays.
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/alsid_pkg.sv
hdl/alsid_intf.sv
hdl/alsid_ctrl.sv
hdl/alsid_dp.sv
hdl/array_list_search_insert_delete.sv
test/tb_array_list_search_insert_delete.sv
